>>> hdl/afns_pkg.sv
// ----------------------------------------------------------------------------
// afns_pkg
// Shared widths, register indexes, word types and helpers for the
// aspect-fit nearest-neighbour scaler.
// ----------------------------------------------------------------------------
package afns_pkg;

  localparam int SRC_DIM_BITS  = 16;
  localparam int FIT_BITS      = 12;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int DIV_BITS      = SRC_DIM_BITS + FIT_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
  localparam int Q_PTR_BITS    = 2;
  localparam int Q_DEPTH       = 1 << Q_PTR_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WIDTH  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_HEIGHT = CFG_IDX_BITS'(3);

  localparam logic [FIT_BITS-1:0] MAX_WIDTH_RST  = FIT_BITS'(800);
  localparam logic [FIT_BITS-1:0] MAX_HEIGHT_RST = FIT_BITS'(600);
  localparam logic [7:0]          ALPHA_OPAQUE   = 8'hFF;

  typedef logic [SRC_DIM_BITS-1:0] sdim_t;
  typedef logic [FIT_BITS-1:0]     fdim_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_word_t;

  typedef struct packed {
    logic      valid;
    pix_word_t word;
  } q_head_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] src_width;
    logic [CFG_DATA_BITS-1:0] src_height;
    fdim_t                    max_width;
    fdim_t                    max_height;
  } cfg_regs_t;

  typedef struct packed {
    fdim_t fit_w;
    fdim_t fit_h;
    sdim_t frame_w;
    sdim_t frame_h;
    sdim_t step_col;
    fdim_t frac_col;
    sdim_t step_row;
    fdim_t frac_row;
  } fit_res_t;

  function automatic sdim_t max1_s(input sdim_t v);
    return (v == '0) ? sdim_t'(1) : v;
  endfunction

  function automatic fdim_t max1_f(input fdim_t v);
    return (v == '0) ? fdim_t'(1) : v;
  endfunction

endpackage

>>> hdl/afns_if.sv
// ----------------------------------------------------------------------------
// afns_if
// Stream and register-write channels of the scaler.
// ----------------------------------------------------------------------------
interface afns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface afns_out_if;
  logic                           valid;
  logic                           ready;
  logic [31:0]                    pixel_argb;
  logic [afns_pkg::FIT_BITS-1:0]  out_col;
  logic [afns_pkg::FIT_BITS-1:0]  out_row;
  logic [afns_pkg::FIT_BITS-1:0]  fitted_width;
  logic [afns_pkg::FIT_BITS-1:0]  fitted_height;
  logic                           frame_last;

  modport source (output valid, pixel_argb, out_col, out_row, fitted_width, fitted_height,
                  frame_last, input ready);
  modport sink   (input valid, pixel_argb, out_col, out_row, fitted_width, fitted_height,
                  frame_last, output ready);
endinterface

interface afns_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [afns_pkg::CFG_IDX_BITS-1:0]  index;
  logic [afns_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/afns_front.sv
// ----------------------------------------------------------------------------
// afns_front
// Takes source words into a short queue and holds the configuration registers.
// ----------------------------------------------------------------------------
module afns_front (
  input  logic                clk,
  input  logic                rst_n,
  afns_in_if.sink             in_bus,
  afns_cfg_if.sink            cfg_bus,
  input  logic                pop,
  output afns_pkg::q_head_t   head,
  output afns_pkg::cfg_regs_t cfg
);

  afns_pkg::pix_word_t                q_mem_r [afns_pkg::Q_DEPTH];
  logic [afns_pkg::Q_PTR_BITS-1:0]    wr_ptr_r;
  logic [afns_pkg::Q_PTR_BITS-1:0]    rd_ptr_r;
  logic [afns_pkg::Q_PTR_BITS:0]      count_r;
  afns_pkg::cfg_regs_t                cfg_r;
  logic                               push;
  logic                               do_pop;

  assign in_bus.ready = (count_r != (afns_pkg::Q_PTR_BITS+1)'(afns_pkg::Q_DEPTH));
  assign push         = in_bus.valid && in_bus.ready;
  assign do_pop       = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.word  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{red: in_bus.red, green: in_bus.green, blue: in_bus.blue,
                             frame_start: in_bus.frame_start};
    end
  end

  // register writes
  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= afns_pkg::CFG_DATA_BITS'(1);
      cfg_r.src_height <= afns_pkg::CFG_DATA_BITS'(1);
      cfg_r.max_width  <= afns_pkg::MAX_WIDTH_RST;
      cfg_r.max_height <= afns_pkg::MAX_HEIGHT_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        afns_pkg::REG_SRC_WIDTH:  cfg_r.src_width  <= cfg_bus.data;
        afns_pkg::REG_SRC_HEIGHT: cfg_r.src_height <= cfg_bus.data;
        afns_pkg::REG_MAX_WIDTH:  cfg_r.max_width  <= cfg_bus.data[afns_pkg::FIT_BITS-1:0];
        afns_pkg::REG_MAX_HEIGHT: cfg_r.max_height <= cfg_bus.data[afns_pkg::FIT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/afns_fit.sv
// ----------------------------------------------------------------------------
// afns_fit
// Per-frame fit sequencer: one multiplier and a shared restoring divider,
// one quotient bit a cycle, for the fitted size and the pick step sizes.
// ----------------------------------------------------------------------------
module afns_fit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  afns_pkg::cfg_regs_t cfg,
  output logic                done,
  output afns_pkg::fit_res_t  res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK1 = 3'd1;
  localparam logic [2:0] ST_CHK2 = 3'd2;
  localparam logic [2:0] ST_LDQW = 3'd3;
  localparam logic [2:0] ST_LDQH = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_POST = 3'd6;

  localparam logic [1:0] OP_FH = 2'd0;
  localparam logic [1:0] OP_FW = 2'd1;
  localparam logic [1:0] OP_QW = 2'd2;
  localparam logic [1:0] OP_QH = 2'd3;

  localparam int SDB = afns_pkg::SRC_DIM_BITS;
  localparam int DB  = afns_pkg::DIV_BITS;
  localparam int FB  = afns_pkg::FIT_BITS;

  logic [2:0]                        state_r, state_nxt;
  logic [1:0]                        op_r, op_nxt;
  logic                              done_r, done_nxt;
  afns_pkg::sdim_t                   w_r, w_nxt, h_r, h_nxt;
  afns_pkg::fdim_t                   mw_r, mw_nxt, mh_r, mh_nxt;
  afns_pkg::sdim_t                   fw_r, fw_nxt, fh_r, fh_nxt;
  afns_pkg::sdim_t                   div_r, div_nxt;
  afns_pkg::sdim_t                   rem_r, rem_nxt;
  logic [DB-1:0]                     quo_r, quo_nxt;
  logic [afns_pkg::DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  afns_pkg::fit_res_t                res_r, res_nxt;
  logic [SDB:0]                      rem_sh;
  logic                              rem_ge;

  assign rem_sh = {rem_r, quo_r[DB-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    done_nxt  = 1'b0;
    w_nxt     = w_r;
    h_nxt     = h_r;
    mw_nxt    = mw_r;
    mh_nxt    = mh_r;
    fw_nxt    = fw_r;
    fh_nxt    = fh_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          w_nxt     = afns_pkg::max1_s(cfg.src_width[SDB-1:0]);
          h_nxt     = afns_pkg::max1_s(cfg.src_height[SDB-1:0]);
          mw_nxt    = afns_pkg::max1_f(cfg.max_width);
          mh_nxt    = afns_pkg::max1_f(cfg.max_height);
          fw_nxt    = afns_pkg::max1_s(cfg.src_width[SDB-1:0]);
          fh_nxt    = afns_pkg::max1_s(cfg.src_height[SDB-1:0]);
          state_nxt = ST_CHK1;
        end
      end
      ST_CHK1: begin
        if (fw_r > mw_r) begin
          quo_nxt   = DB'(fh_r) * DB'(mw_r);
          div_nxt   = fw_r;
          rem_nxt   = '0;
          cnt_nxt   = afns_pkg::DIV_CNT_BITS'(DB - 1);
          op_nxt    = OP_FH;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_CHK2;
        end
      end
      ST_CHK2: begin
        if (fh_r > mh_r) begin
          quo_nxt   = DB'(fw_r) * DB'(mh_r);
          div_nxt   = fh_r;
          rem_nxt   = '0;
          cnt_nxt   = afns_pkg::DIV_CNT_BITS'(DB - 1);
          op_nxt    = OP_FW;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_LDQW;
        end
      end
      ST_LDQW: begin
        quo_nxt   = DB'(w_r);
        div_nxt   = fw_r;
        rem_nxt   = '0;
        cnt_nxt   = afns_pkg::DIV_CNT_BITS'(DB - 1);
        op_nxt    = OP_QW;
        state_nxt = ST_DIV;
      end
      ST_LDQH: begin
        quo_nxt   = DB'(h_r);
        div_nxt   = fh_r;
        rem_nxt   = '0;
        cnt_nxt   = afns_pkg::DIV_CNT_BITS'(DB - 1);
        op_nxt    = OP_QH;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? SDB'(rem_sh - {1'b0, div_r}) : SDB'(rem_sh);
        quo_nxt = {quo_r[DB-2:0], rem_ge};
        if (cnt_r == '0) begin
          state_nxt = ST_POST;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_POST: begin
        unique case (op_r)
          OP_FH: begin
            fh_nxt    = afns_pkg::max1_s(SDB'(quo_r));
            fw_nxt    = SDB'(mw_r);
            state_nxt = ST_CHK2;
          end
          OP_FW: begin
            fw_nxt    = SDB'(afns_pkg::max1_f(FB'(quo_r)));
            fh_nxt    = SDB'(mh_r);
            state_nxt = ST_LDQW;
          end
          OP_QW: begin
            res_nxt.step_col = SDB'(quo_r);
            res_nxt.frac_col = FB'(rem_r);
            state_nxt        = ST_LDQH;
          end
          OP_QH: begin
            res_nxt.step_row = SDB'(quo_r);
            res_nxt.frac_row = FB'(rem_r);
            res_nxt.fit_w    = FB'(fw_r);
            res_nxt.fit_h    = FB'(fh_r);
            res_nxt.frame_w  = w_r;
            res_nxt.frame_h  = h_r;
            done_nxt         = 1'b1;
            state_nxt        = ST_IDLE;
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    w_r   <= w_nxt;
    h_r   <= h_nxt;
    mw_r  <= mw_nxt;
    mh_r  <= mh_nxt;
    fw_r  <= fw_nxt;
    fh_r  <= fh_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> hdl/afns_back.sv
// ----------------------------------------------------------------------------
// afns_back
// Walks the source raster, picks the nearest source pixel for each output
// position with quotient/remainder counters and holds the result word.
// ----------------------------------------------------------------------------
module afns_back (
  input  logic               clk,
  input  logic               rst_n,
  input  afns_pkg::q_head_t  head,
  output logic               pop,
  output logic               fit_start,
  input  logic               fit_done,
  input  afns_pkg::fit_res_t fit_res,
  afns_out_if.source         out_bus
);

  localparam int SDB = afns_pkg::SRC_DIM_BITS;
  localparam int FB  = afns_pkg::FIT_BITS;

  logic            fit_wait_r, fitted_r;
  afns_pkg::sdim_t frame_w_r, frame_h_r;
  afns_pkg::fdim_t fit_w_r, fit_h_r;
  afns_pkg::sdim_t step_col_r, step_row_r;
  afns_pkg::fdim_t frac_col_r, frac_row_r;
  afns_pkg::sdim_t src_col_r, src_row_r;
  afns_pkg::fdim_t dst_col_r, dst_row_r;
  afns_pkg::sdim_t pick_col_r, pick_row_r;
  afns_pkg::fdim_t pick_col_rem_r, pick_row_rem_r;

  logic            out_valid_r;
  logic [31:0]     argb_o_r;
  afns_pkg::fdim_t col_o_r, row_o_r, fw_o_r, fh_o_r;
  logic            last_o_r;

  logic            out_free, hit, last_col, last_row;
  logic [FB:0]     col_sum, row_sum;
  logic            col_wrap, row_wrap;
  logic [SDB:0]    src_col_inc;
  logic            src_wrap;

  assign fit_start = head.valid && head.word.frame_start && !fitted_r && !fit_wait_r;
  assign out_free  = !out_valid_r || out_bus.ready;
  assign pop       = head.valid && (!head.word.frame_start || fitted_r) && out_free;

  assign hit = (dst_row_r < fit_h_r) && (dst_col_r < fit_w_r) &&
               (src_row_r == pick_row_r) && (src_col_r == pick_col_r);
  assign last_col = (dst_col_r == fit_w_r - FB'(1));
  assign last_row = (dst_row_r == fit_h_r - FB'(1));

  assign col_sum  = {1'b0, pick_col_rem_r} + {1'b0, frac_col_r};
  assign row_sum  = {1'b0, pick_row_rem_r} + {1'b0, frac_row_r};
  assign col_wrap = (col_sum >= {1'b0, fit_w_r});
  assign row_wrap = (row_sum >= {1'b0, fit_h_r});

  assign src_col_inc = {1'b0, src_col_r} + (SDB+1)'(1);
  assign src_wrap    = (src_col_inc >= {1'b0, frame_w_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_wait_r     <= 1'b0;
      fitted_r       <= 1'b0;
      frame_w_r      <= SDB'(1);
      frame_h_r      <= SDB'(1);
      fit_w_r        <= FB'(1);
      fit_h_r        <= FB'(1);
      step_col_r     <= SDB'(1);
      step_row_r     <= SDB'(1);
      frac_col_r     <= '0;
      frac_row_r     <= '0;
      src_col_r      <= '0;
      src_row_r      <= '0;
      dst_col_r      <= '0;
      dst_row_r      <= '0;
      pick_col_r     <= '0;
      pick_row_r     <= '0;
      pick_col_rem_r <= '0;
      pick_row_rem_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (fit_start) begin
        fit_wait_r <= 1'b1;
      end
      if (fit_done) begin
        fit_wait_r     <= 1'b0;
        fitted_r       <= 1'b1;
        frame_w_r      <= fit_res.frame_w;
        frame_h_r      <= fit_res.frame_h;
        fit_w_r        <= fit_res.fit_w;
        fit_h_r        <= fit_res.fit_h;
        step_col_r     <= fit_res.step_col;
        step_row_r     <= fit_res.step_row;
        frac_col_r     <= fit_res.frac_col;
        frac_row_r     <= fit_res.frac_row;
        src_col_r      <= '0;
        src_row_r      <= '0;
        dst_col_r      <= '0;
        dst_row_r      <= '0;
        pick_col_r     <= '0;
        pick_row_r     <= '0;
        pick_col_rem_r <= '0;
        pick_row_rem_r <= '0;
      end else if (pop) begin
        fitted_r <= 1'b0;
        if (hit) begin
          if (last_col) begin
            dst_col_r      <= '0;
            pick_col_r     <= '0;
            pick_col_rem_r <= '0;
            dst_row_r      <= dst_row_r + FB'(1);
            pick_row_r     <= pick_row_r + step_row_r + SDB'(row_wrap);
            pick_row_rem_r <= row_wrap ? FB'(row_sum - {1'b0, fit_h_r}) : FB'(row_sum);
          end else begin
            dst_col_r      <= dst_col_r + FB'(1);
            pick_col_r     <= pick_col_r + step_col_r + SDB'(col_wrap);
            pick_col_rem_r <= col_wrap ? FB'(col_sum - {1'b0, fit_w_r}) : FB'(col_sum);
          end
        end
        if (src_wrap) begin
          src_col_r <= '0;
          if (src_row_r != '1) begin
            src_row_r <= src_row_r + SDB'(1);
          end
        end else begin
          src_col_r <= SDB'(src_col_inc);
        end
      end
      if (out_free) begin
        out_valid_r <= pop && hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && hit) begin
      argb_o_r <= {afns_pkg::ALPHA_OPAQUE, head.word.red, head.word.green, head.word.blue};
      col_o_r  <= dst_col_r;
      row_o_r  <= dst_row_r;
      fw_o_r   <= fit_w_r;
      fh_o_r   <= fit_h_r;
      last_o_r <= last_col && last_row;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.pixel_argb    = argb_o_r;
  assign out_bus.out_col       = col_o_r;
  assign out_bus.out_row       = row_o_r;
  assign out_bus.fitted_width  = fw_o_r;
  assign out_bus.fitted_height = fh_o_r;
  assign out_bus.frame_last    = last_o_r;

`ifndef ASSERT_OFF
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    fit_done |-> fit_wait_r)
    else $error("fit result arrived with no fit outstanding");

  a_hold_during_fit: assert property (@(posedge clk) disable iff (!rst_n)
    fit_wait_r |-> !pop)
    else $error("word consumed while the fit is still running");

  a_col_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    pick_col_rem_r < fit_w_r)
    else $error("column remainder out of range");

  a_row_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    pick_row_rem_r < fit_h_r)
    else $error("row remainder out of range");

  a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (col_o_r < fw_o_r))
    else $error("output column beyond fitted width");
`endif

endmodule

>>> hdl/aspect_fit_nearest_scaler_unit.sv
// ----------------------------------------------------------------------------
// aspect_fit_nearest_scaler_unit
// Aspect-fit nearest-neighbour downscaler for an RGB raster stream.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                           handshake
//  in_bus    in   red, green, blue, frame_start                    valid/ready
//  out_bus   out  pixel_argb, out_col, out_row, fitted_width,
//                 fitted_height, frame_last                         valid/ready
//  cfg_bus   in   index, data (src_width, src_height, max_width,
//                 max_height)                                       valid/ready
//
//  A plain pixel word is taken and mapped at one word a cycle while out_bus is not stalled.
//  A word with frame_start waits at the queue head until the fit sequencer,
//  with its bit-serial divider, has finished.
//  A four-word queue lets input continue while the back end waits on out_bus or the fit.
//  rst_n is synchronous; after reset the block acts as on a 1x1 frame.
// ----------------------------------------------------------------------------
module aspect_fit_nearest_scaler_unit (
  input  logic       clk,
  input  logic       rst_n,
  afns_in_if.sink    in_bus,
  afns_out_if.source out_bus,
  afns_cfg_if.sink   cfg_bus
);

  afns_pkg::q_head_t   head;
  afns_pkg::cfg_regs_t cfg;
  afns_pkg::fit_res_t  fit_res;
  logic                pop;
  logic                fit_start;
  logic                fit_done;

  afns_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .pop     (pop),
    .head    (head),
    .cfg     (cfg)
  );

  afns_fit u_fit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fit_start),
    .cfg   (cfg),
    .done  (fit_done),
    .res   (fit_res)
  );

  afns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .fit_start (fit_start),
    .fit_done  (fit_done),
    .fit_res   (fit_res),
    .out_bus   (out_bus)
  );

endmodule

>>> dv/afns_scaler_checker.sv
// ----------------------------------------------------------------------------
// afns_scaler_checker
// Watches the register, pixel and result channels of the scaler. Mirrors
// the fit and pick counters per accepted pixel word, queues the scaled
// pixels it predicts and compares every accepted result word against the
// oldest of them, field by field.
// ----------------------------------------------------------------------------
module afns_scaler_checker
  import afns_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  afns_in_if   in_bus,
  afns_out_if  out_bus,
  afns_cfg_if  cfg_bus,
  output int   mismatch_count,
  output int   pending_count
);

  typedef struct packed {
    logic [31:0] pixel_argb;
    fdim_t       out_col;
    fdim_t       out_row;
    fdim_t       fitted_width;
    fdim_t       fitted_height;
    logic        frame_last;
  } scaled_pix_t;

  scaled_pix_t pending_pixels[$];
  int          errs = 0;

  sdim_t       src_w_reg, src_h_reg;
  fdim_t       max_w_reg, max_h_reg;
  sdim_t       frame_w, frame_h;
  fdim_t       fit_w, fit_h;
  logic [31:0] src_col, src_row, dst_col, dst_row;
  logic [31:0] pick_col, pick_col_rem, pick_row, pick_row_rem;

  function automatic logic [31:0] floor_one(input logic [31:0] v);
    return (v == 0) ? 32'd1 : v;
  endfunction

  task automatic clear_counters();
    src_col = 0; src_row = 0;
    dst_col = 0; dst_row = 0;
    pick_col = 0; pick_col_rem = 0;
    pick_row = 0; pick_row_rem = 0;
  endtask

  task automatic reset_scaler();
    src_w_reg = sdim_t'(1);
    src_h_reg = sdim_t'(1);
    max_w_reg = MAX_WIDTH_RST;
    max_h_reg = MAX_HEIGHT_RST;
    frame_w = sdim_t'(1);
    frame_h = sdim_t'(1);
    fit_w = fdim_t'(1);
    fit_h = fdim_t'(1);
    clear_counters();
  endtask

  task automatic latch_fit();
    logic [31:0] w, h, mw, mh, fw, fh;
    logic [63:0] prod;
    w = floor_one(32'(src_w_reg));
    h = floor_one(32'(src_h_reg));
    mw = floor_one(32'(max_w_reg));
    mh = floor_one(32'(max_h_reg));
    fw = w;
    fh = h;
    if (fw > mw) begin
      prod = 64'(fh) * 64'(mw);
      fh = floor_one(32'(prod / 64'(fw)));
      fw = mw;
    end
    if (fh > mh) begin
      prod = 64'(fw) * 64'(mh);
      fw = floor_one(32'(prod / 64'(fh)));
      fh = mh;
    end
    frame_w = sdim_t'(w);
    frame_h = sdim_t'(h);
    fit_w = fdim_t'(fw);
    fit_h = fdim_t'(fh);
    clear_counters();
  endtask

  task automatic predict_pixel(input pix_word_t wd);
    scaled_pix_t px;
    logic        last_col;
    if (wd.frame_start)
      latch_fit();
    if (dst_row < fit_h && dst_col < fit_w && src_row == pick_row && src_col == pick_col) begin
      last_col = (dst_col == 32'(fit_w) - 1);
      px.pixel_argb = {ALPHA_OPAQUE, wd.red, wd.green, wd.blue};
      px.out_col = dst_col[FIT_BITS-1:0];
      px.out_row = dst_row[FIT_BITS-1:0];
      px.fitted_width = fit_w;
      px.fitted_height = fit_h;
      px.frame_last = last_col && (dst_row == 32'(fit_h) - 1);
      pending_pixels.push_back(px);
      if (last_col) begin
        dst_col = 0;
        pick_col = 0;
        pick_col_rem = 0;
        dst_row++;
        pick_row += 32'(frame_h) / 32'(fit_h);
        pick_row_rem += 32'(frame_h) % 32'(fit_h);
        if (pick_row_rem >= 32'(fit_h)) begin
          pick_row_rem -= 32'(fit_h);
          pick_row++;
        end
      end else begin
        dst_col++;
        pick_col += 32'(frame_w) / 32'(fit_w);
        pick_col_rem += 32'(frame_w) % 32'(fit_w);
        if (pick_col_rem >= 32'(fit_w)) begin
          pick_col_rem -= 32'(fit_w);
          pick_col++;
        end
      end
    end
    if (src_col + 1 >= 32'(frame_w)) begin
      src_col = 0;
      if (src_row < 32'((1 << SRC_DIM_BITS) - 1))
        src_row++;
    end else begin
      src_col++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    scaled_pix_t got, want;
    if (!rst_n) begin
      reset_scaler();
      pending_pixels.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_SRC_WIDTH:  src_w_reg = sdim_t'(cfg_bus.data);
          REG_SRC_HEIGHT: src_h_reg = sdim_t'(cfg_bus.data);
          REG_MAX_WIDTH:  max_w_reg = fdim_t'(cfg_bus.data);
          REG_MAX_HEIGHT: max_h_reg = fdim_t'(cfg_bus.data);
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready)
        predict_pixel('{red: in_bus.red, green: in_bus.green, blue: in_bus.blue,
                        frame_start: in_bus.frame_start});
      if (out_bus.valid && out_bus.ready) begin
        got = '{pixel_argb: out_bus.pixel_argb, out_col: out_bus.out_col,
                out_row: out_bus.out_row, fitted_width: out_bus.fitted_width,
                fitted_height: out_bus.fitted_height, frame_last: out_bus.frame_last};
        if (pending_pixels.size() == 0) begin
          errs++;
          $display("%0t: unexpected word, expected none actual %0h", $time, got);
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_argb", want.pixel_argb, got.pixel_argb);
          check_field("out_col", 32'(want.out_col), 32'(got.out_col));
          check_field("out_row", 32'(want.out_row), 32'(got.out_row));
          check_field("fitted_width", 32'(want.fitted_width), 32'(got.fitted_width));
          check_field("fitted_height", 32'(want.fitted_height), 32'(got.fitted_height));
          check_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
        end
      end
    end
    mismatch_count <= errs;
    pending_count <= pending_pixels.size();
  end

endmodule

>>> dv/tb_aspect_fit_nearest_scaler_unit.sv
// ----------------------------------------------------------------------------
// tb_aspect_fit_nearest_scaler_unit
// Drives pixel frames and register settings into the scaler: a directed
// pass over size extremes and corner cases, then random phases of mostly
// well-formed frames with truncated, overlong and restarted ones mixed in,
// under varying sender idling and receiver stalls. Checking is done by
// afns_scaler_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_aspect_fit_nearest_scaler_unit;
  import afns_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int DRAIN_CYCLES = 4 * DIV_BITS + 9 + 8 * Q_DEPTH;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(REG_MAX_HEIGHT + 1);
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP   = '1;

  logic clk;
  logic rst_n;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   words_sent = 0;
  int   mismatch_count;
  int   pending_count;
  int   cycles;

  afns_in_if  in_bus ();
  afns_out_if out_bus ();
  afns_cfg_if cfg_bus ();

  aspect_fit_nearest_scaler_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  afns_scaler_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (in_bus),
    .out_bus        (out_bus),
    .cfg_bus        (cfg_bus),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 65; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 65; end
      default: begin idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fs);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.red <= r;
    in_bus.green <= g;
    in_bus.blue <= b;
    in_bus.frame_start <= fs;
    do @(posedge clk); while (!in_bus.ready);
    words_sent++;
  endtask

  // first word opens a frame when asked; later words restart one now and then
  task automatic send_run(input int n, input logic open_frame);
    for (int i = 0; i < n; i++)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 (i == 0) ? open_frame : ($urandom_range(99) < 2));
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic program_scaler(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] mw, input logic [15:0] mh);
    settle();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_MAX_WIDTH, mw);
    write_reg(REG_MAX_HEIGHT, mh);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    int unsigned w, h, mw, mh, area, n, kind, phase;
    logic        small_frame;
    in_bus.valid <= 1'b0;
    in_bus.red <= '0;
    in_bus.green <= '0;
    in_bus.blue <= '0;
    in_bus.frame_start <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_SRC_WIDTH;
    cfg_bus.data <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state acts as a 1x1 frame, then a word past its end
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);

    // zero sizes count as one; spare indexes are ignored
    settle();
    write_reg(REG_SRC_WIDTH, 16'h0000);
    write_reg(REG_SRC_HEIGHT, 16'h0000);
    write_reg(REG_MAX_WIDTH, 16'h0000);
    write_reg(REG_MAX_HEIGHT, 16'h0000);
    write_reg(REG_SPARE, '1);
    write_reg(REG_TOP, 16'h0005);
    cfg_bus.valid <= 1'b0;
    send_pixel(8'hAA, 8'h55, 8'hA5, 1'b1);
    send_pixel(8'h5A, 8'hC3, 8'h3C, 1'b0);

    program_scaler(16'hFFFF, 16'hFFFF, 16'h0FFF, 16'h0FFF);
    send_run(4, 1'b1);
    program_scaler(16'hFFFF, 16'h0001, 16'h0001, 16'h0001);
    send_run(3, 1'b1);
    program_scaler(16'h0001, 16'hFFFF, 16'h0FFF, 16'h0001);
    send_run(3, 1'b1);
    program_scaler(16'd4, 16'd2, 16'd2, 16'd2);
    send_run(9, 1'b1);

    phase = 0;
    while (words_sent < RANDOM_WORDS + 25) begin
      set_idling(phase);
      kind = $urandom_range(9);
      small_frame = 1'b0;
      if (kind == 0) begin
        w = $urandom_range(16'hFFFF);
        h = $urandom_range(16'hFFFF);
        mw = $urandom_range(12'hFFF);
        mh = $urandom_range(12'hFFF);
      end else if (kind == 1) begin
        w = $urandom_range(1) ? 16'hFFFF : 16'h0001;
        h = $urandom_range(1) ? 16'hFFFF : 16'h0001;
        mw = $urandom_range(1) ? 12'hFFF : 12'h001;
        mh = $urandom_range(1) ? 12'hFFF : 12'h001;
      end else begin
        small_frame = 1'b1;
        w = $urandom_range(20, 1);
        h = $urandom_range(16, 1);
        mw = $urandom_range(12, 1);
        mh = $urandom_range(10, 1);
      end
      program_scaler(16'(w), 16'(h), 16'(mw), 16'(mh));
      // a frame left open carries on with the fit latched at its start
      if ($urandom_range(3) == 0)
        send_run($urandom_range(8, 1), 1'b0);
      repeat ($urandom_range(3, 1)) begin
        if (small_frame) begin
          area = w * h;
          case ($urandom_range(19))
            0, 1, 2: n = $urandom_range(area, 1);
            3, 4, 5: n = area + $urandom_range(6, 1);
            default: n = area;
          endcase
        end else begin
          n = $urandom_range(40, 1);
        end
        send_run(n, 1'b1);
      end
      phase++;
    end

    settle();
    if (mismatch_count == 0 && pending_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
